FILE: sv/dtq_pkg.sv
`default_nettype none
package dtq_pkg;
   localparam int TimerSlots = 32;
   localparam int SlotWidth = $clog2(TimerSlots);
   localparam int LinkWidth = 6;
   localparam logic [LinkWidth-1:0] NilLink = 6'd63;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_TICK = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_ZERO_DELAY = 2'd1,
      STATUS_QUEUED = 2'd2,
      STATUS_NOT_QUEUED = 2'd3
   } status_type;
endpackage
`default_nettype wire

FILE: sv/delta_timer_queue.sv
// One transaction at a time: a request is stalled while the sequencer is busy or a
// response waits to be taken. The add walk reads one list entry per step.
// Reset (synchronous, active high) empties the list and clears all queued flags;
// entry stores are left as they are and are only read once queued.
`default_nettype none
module delta_timer_queue import dtq_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_func,
   input wire logic [4:0] req_timer_slot,
   input wire logic [31:0] req_delay,
   input wire logic [11:0] req_proc_id,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic rsp_expired_valid,
   output logic [4:0] rsp_expired_slot,
   output logic [11:0] rsp_expired_proc,
   output logic rsp_last
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_ADD_RD, ST_ADD_CMP, ST_ADD_LINK, ST_DEL_RD, ST_DEL_FOLD,
      ST_TICK_RD, ST_TICK_DEC, ST_TICK_CHK, ST_OUT
   } state_type;

   state_type state_ff;
   logic [31:0] delta_mem [TimerSlots];
   logic [11:0] proc_mem [TimerSlots];
   logic [LinkWidth-1:0] next_mem [TimerSlots];
   logic [LinkWidth-1:0] prev_mem [TimerSlots];
   logic [TimerSlots-1:0] queued_ff;
   logic [LinkWidth-1:0] head_ff, tail_ff, cur_ff;
   logic [SlotWidth-1:0] slot_ff;
   logic [31:0] delay_ff, rd_ff;
   logic [11:0] proc_ff;
   logic more_ff;

   // Convert a link to a memory index; only used on links that are not null.
   function automatic logic [SlotWidth-1:0] idx(input logic [LinkWidth-1:0] l);
      return l[SlotWidth-1:0];
   endfunction

   function automatic logic is_slot(input logic [LinkWidth-1:0] l);
      return l != NilLink && int'(l) < TimerSlots;
   endfunction

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid;

   // Sequencer for the add, delete and tick transactions.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         queued_ff <= '0;
         head_ff <= NilLink;
         tail_ff <= NilLink;
         rsp_valid <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_stall) begin
                  slot_ff <= req_timer_slot;
                  delay_ff <= req_delay;
                  proc_ff <= req_proc_id;
                  rsp_expired_valid <= 1'b0;
                  rsp_expired_slot <= '0;
                  rsp_expired_proc <= '0;
                  rsp_last <= 1'b1;
                  rsp_status <= STATUS_DONE;
                  unique case (func_type'(req_func))
                     FUNC_ADD: begin
                        if (req_delay == '0) begin
                           rsp_status <= STATUS_ZERO_DELAY;
                           rsp_valid <= 1'b1;
                        end else if (!is_slot({1'b0, req_timer_slot})) begin
                           rsp_status <= STATUS_NOT_QUEUED;
                           rsp_valid <= 1'b1;
                        end else if (queued_ff[req_timer_slot]) begin
                           rsp_status <= STATUS_QUEUED;
                           rsp_valid <= 1'b1;
                        end else begin
                           cur_ff <= head_ff;
                           state_ff <= ST_ADD_RD;
                        end
                     end
                     FUNC_DELETE: begin
                        if (!is_slot({1'b0, req_timer_slot}) ||
                            !queued_ff[req_timer_slot]) begin
                           rsp_status <= STATUS_NOT_QUEUED;
                           rsp_valid <= 1'b1;
                        end else begin
                           state_ff <= ST_DEL_RD;
                        end
                     end
                     FUNC_TICK: begin
                        if (is_slot(head_ff)) state_ff <= ST_TICK_RD;
                        else rsp_valid <= 1'b1;
                     end
                     default: rsp_valid <= 1'b1;
                  endcase
               end
            end
            // Add: read the current entry's delta, or go to the link step at the end of the list.
            ST_ADD_RD: begin
               if (is_slot(cur_ff)) begin
                  rd_ff <= delta_mem[idx(cur_ff)];
                  state_ff <= ST_ADD_CMP;
               end else begin
                  state_ff <= ST_ADD_LINK;
               end
            end
            // Add: stop before the first larger delta, else pass the entry.
            ST_ADD_CMP: begin
               if (delay_ff < rd_ff) begin
                  delta_mem[idx(cur_ff)] <= rd_ff - delay_ff;
                  state_ff <= ST_ADD_LINK;
               end else begin
                  delay_ff <= delay_ff - rd_ff;
                  cur_ff <= next_mem[idx(cur_ff)];
                  state_ff <= ST_ADD_RD;
               end
            end
            // Add: splice the new slot in before cur.
            ST_ADD_LINK: begin : add_link
               logic [LinkWidth-1:0] p;
               p = is_slot(cur_ff) ? prev_mem[idx(cur_ff)] : tail_ff;
               if (!is_slot(p)) p = NilLink;
               prev_mem[slot_ff] <= p;
               next_mem[slot_ff] <= cur_ff;
               if (is_slot(p)) next_mem[idx(p)] <= {1'b0, slot_ff};
               else head_ff <= {1'b0, slot_ff};
               if (is_slot(cur_ff)) prev_mem[idx(cur_ff)] <= {1'b0, slot_ff};
               else tail_ff <= {1'b0, slot_ff};
               delta_mem[slot_ff] <= delay_ff;
               proc_mem[slot_ff] <= proc_ff;
               queued_ff[slot_ff] <= 1'b1;
               rsp_valid <= 1'b1;
               state_ff <= ST_IDLE;
            end
            // Delete: read the deleted delta and the successor.
            ST_DEL_RD: begin
               rd_ff <= delta_mem[slot_ff];
               cur_ff <= next_mem[slot_ff];
               state_ff <= ST_DEL_FOLD;
            end
            // Delete: fold the delta into the successor and unlink.
            ST_DEL_FOLD: begin : del_fold
               logic [LinkWidth-1:0] p;
               p = prev_mem[slot_ff];
               if (is_slot(cur_ff)) begin
                  delta_mem[idx(cur_ff)] <= delta_mem[idx(cur_ff)] + rd_ff;
                  prev_mem[idx(cur_ff)] <= p;
               end else begin
                  tail_ff <= p;
               end
               if (is_slot(p)) next_mem[idx(p)] <= cur_ff;
               else head_ff <= cur_ff;
               queued_ff[slot_ff] <= 1'b0;
               rsp_valid <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_TICK_RD: begin
               rd_ff <= delta_mem[idx(head_ff)];
               state_ff <= ST_TICK_DEC;
            end
            // Tick: decrement the head, saturating at zero.
            ST_TICK_DEC: begin
               if (rd_ff != '0) begin
                  delta_mem[idx(head_ff)] <= rd_ff - 32'd1;
                  rd_ff <= rd_ff - 32'd1;
               end
               more_ff <= 1'b0;
               state_ff <= ST_TICK_CHK;
            end
            // Tick: once any pending response is taken, expire the head when its delta is zero, else end the tick.
            ST_TICK_CHK: begin
               if (!rsp_valid || !rsp_stall) begin
                  if (is_slot(head_ff) && rd_ff == '0) begin
                     cur_ff <= next_mem[idx(head_ff)];
                     rsp_expired_valid <= 1'b1;
                     rsp_expired_slot <= head_ff[4:0];
                     rsp_expired_proc <= proc_mem[idx(head_ff)];
                     rsp_status <= STATUS_DONE;
                     queued_ff[idx(head_ff)] <= 1'b0;
                     more_ff <= 1'b1;
                     state_ff <= ST_OUT;
                  end else begin
                     if (!more_ff) begin
                        rsp_expired_valid <= 1'b0;
                        rsp_expired_slot <= '0;
                        rsp_expired_proc <= '0;
                        rsp_status <= STATUS_DONE;
                        rsp_last <= 1'b1;
                        rsp_valid <= 1'b1;
                     end
                     state_ff <= ST_IDLE;
                  end
               end
            end
            // Tick: unlink the expired head, look ahead, and present the result.
            ST_OUT: begin
               head_ff <= cur_ff;
               if (is_slot(cur_ff)) begin
                  prev_mem[idx(cur_ff)] <= NilLink;
                  rd_ff <= delta_mem[idx(cur_ff)];
                  rsp_last <= (delta_mem[idx(cur_ff)] != '0);
               end else begin
                  tail_ff <= NilLink;
                  rsp_last <= 1'b1;
               end
               rsp_valid <= 1'b1;
               state_ff <= ST_TICK_CHK;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
